/* design/btnf_pkg.sv */
// Shared types and constants of the boundary-tag next-fit allocator.
// No dependencies; used by btnf_core and the top level.
`default_nettype none
package btnf_pkg;
	localparam int AW = 17;
	localparam int WW = 13;
	localparam logic [WW-1:0] NULL_LINK = 13'h1FFF;
	localparam logic [AW-1:0] ADDR_SPACE = 17'd4096;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_INIT  = 2'd2;
	localparam logic [1:0] CMD_DONE  = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [11:0] request_size;
		logic [11:0] free_address;
	} item_t;

	typedef struct packed {
		logic [11:0] payload_address;
		logic        ok;
	} res_t;
endpackage
`default_nettype wire

/* design/btnf_core.sv */
// Command sequencer and pool memory of the allocator.
// Depends on btnf_pkg.
`default_nettype none
module btnf_core #(
	parameter int POOL_DEPTH     = 4096,
	parameter int BLOCK_OVERHEAD = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire btnf_pkg::item_t    item,
	input  wire logic [12:0]        pool_words,
	input  wire logic               res_room,
	output logic                    idle,
	output logic                    res_valid,
	output btnf_pkg::res_t          res
);
	localparam int AW  = btnf_pkg::AW;
	localparam int WW  = btnf_pkg::WW;
	localparam int MAW = $clog2(POOL_DEPTH);
	localparam logic [AW-1:0] DEPTH = AW'(POOL_DEPTH);
	localparam logic [AW-1:0] OV    = AW'(BLOCK_OVERHEAD);
	localparam logic [AW-1:0] OVM1  = AW'(BLOCK_OVERHEAD - 1);
	localparam logic [AW-1:0] OV2   = AW'(2 * BLOCK_OVERHEAD);
	localparam logic [AW-1:0] OV2M1 = AW'(2 * BLOCK_OVERHEAD - 1);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_FIN    = 5'd2;
	localparam logic [4:0] S_A_CHK  = 5'd3;
	localparam logic [4:0] S_A_S    = 5'd4;
	localparam logic [4:0] S_A_ADV  = 5'd5;
	localparam logic [4:0] S_A_BN   = 5'd6;
	localparam logic [4:0] S_A_BP   = 5'd7;
	localparam logic [4:0] S_A_WR   = 5'd8;
	localparam logic [4:0] S_F_LINK = 5'd9;
	localparam logic [4:0] S_F_SIZE = 5'd10;
	localparam logic [4:0] S_F_NLNK = 5'd11;
	localparam logic [4:0] S_F_NP   = 5'd12;
	localparam logic [4:0] S_F_NS   = 5'd13;
	localparam logic [4:0] S_F_MWR  = 5'd14;
	localparam logic [4:0] S_F_PFR  = 5'd15;
	localparam logic [4:0] S_F_PF   = 5'd16;
	localparam logic [4:0] S_F_PLNK = 5'd17;
	localparam logic [4:0] S_F_PS   = 5'd18;
	localparam logic [4:0] S_F_PWR  = 5'd19;
	localparam logic [4:0] S_F_HRD  = 5'd20;
	localparam logic [4:0] S_F_H    = 5'd21;
	localparam logic [4:0] S_F_HWR  = 5'd22;
	localparam logic [4:0] S_I_WR   = 5'd23;

	logic [4:0]    state_q;
	logic [3:0]    step_q;
	logic [1:0]    cmd_q;
	logic [11:0]   req_q;
	logic [11:0]   fa_q;
	logic [AW-1:0] b_q, nb_q, pb_q, n_q, rover_q;
	logic [WW-1:0] s_q, bn_q, bp_q, ns_q, nn_q, np_q, h_q, limit_q;
	logic          whole_q, active_q, ok_q, rd_oob_q;
	logic [11:0]   addr_q;

	logic [WW-1:0] mem [POOL_DEPTH];
	logic [WW-1:0] mem_q;
	logic [WW-1:0] rdata;
	logic          mem_re, mem_we, w_last;
	logic [AW-1:0] acc_addr;
	logic [WW-1:0] wdata;
	logic          in_range;

	logic [AW-1:0] pw, req_x, fa_x, rd_x, b_free, nb_free, pb_calc;

	assign pw      = AW'(pool_words);
	assign req_x   = AW'(req_q);
	assign fa_x    = AW'(fa_q);
	assign rd_x    = AW'(rdata);
	assign b_free  = fa_x - OVM1;
	assign nb_free = b_q + OV + rd_x;
	assign pb_calc = b_q - rd_x - OV;
	assign rdata   = rd_oob_q ? '0 : mem_q;
	assign in_range = acc_addr < DEPTH;
	assign idle    = (state_q == S_IDLE);

	always_comb begin
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		acc_addr = '0;
		wdata    = '0;
		w_last   = 1'b0;
		case (state_q)
			S_DISP: begin
				mem_re   = 1'b1;
				acc_addr = b_free + AW'(1);
			end
			S_A_CHK: begin
				mem_re   = 1'b1;
				acc_addr = (b_q != '0) ? b_q : b_q + AW'(1);
			end
			S_A_S: begin
				mem_re   = 1'b1;
				acc_addr = b_q + AW'(1);
			end
			S_A_BN: begin
				mem_re   = 1'b1;
				acc_addr = b_q + AW'(2);
			end
			S_A_WR: begin
				mem_we = 1'b1;
				if (whole_q) begin
					case (step_q)
						4'd0: begin acc_addr = AW'(bp_q) + AW'(1); wdata = bn_q; end
						4'd1: begin acc_addr = AW'(bn_q) + AW'(2); wdata = bp_q; end
						4'd2: begin acc_addr = b_q + AW'(1); wdata = btnf_pkg::NULL_LINK; end
						default: begin
							acc_addr = b_q + OVM1 + AW'(s_q);
							wdata    = s_q;
							w_last   = 1'b1;
						end
					endcase
				end else begin
					case (step_q)
						4'd0: begin acc_addr = nb_q + AW'(2); wdata = bp_q; end
						4'd1: begin acc_addr = nb_q + AW'(1); wdata = bn_q; end
						4'd2: begin acc_addr = AW'(bn_q) + AW'(2); wdata = nb_q[WW-1:0]; end
						4'd3: begin acc_addr = AW'(bp_q) + AW'(1); wdata = nb_q[WW-1:0]; end
						4'd4: begin acc_addr = b_q + AW'(1); wdata = btnf_pkg::NULL_LINK; end
						4'd5: begin acc_addr = nb_q; wdata = ns_q; end
						4'd6: begin acc_addr = nb_q + OVM1 + AW'(ns_q); wdata = ns_q; end
						4'd7: begin acc_addr = b_q; wdata = WW'(req_q); end
						default: begin
							acc_addr = b_q + OVM1 + req_x;
							wdata    = WW'(req_q);
							w_last   = 1'b1;
						end
					endcase
				end
			end
			S_F_LINK: begin
				mem_re   = 1'b1;
				acc_addr = b_q;
			end
			S_F_SIZE: begin
				mem_re   = 1'b1;
				acc_addr = nb_free + AW'(1);
			end
			S_F_NLNK: begin
				mem_re   = 1'b1;
				acc_addr = nb_q + AW'(2);
			end
			S_F_NP: begin
				mem_re   = 1'b1;
				acc_addr = nb_q;
			end
			S_F_MWR: begin
				mem_we = 1'b1;
				case (step_q)
					4'd0: begin acc_addr = b_q; wdata = s_q; end
					4'd1: begin acc_addr = AW'(np_q) + AW'(1); wdata = nn_q; end
					4'd2: begin acc_addr = AW'(nn_q) + AW'(2); wdata = np_q; end
					default: begin
						acc_addr = b_q + OVM1 + AW'(s_q);
						wdata    = s_q;
						w_last   = 1'b1;
					end
				endcase
			end
			S_F_PFR: begin
				mem_re   = 1'b1;
				acc_addr = b_q - AW'(1);
			end
			S_F_PF: begin
				mem_re   = 1'b1;
				acc_addr = pb_calc + AW'(1);
			end
			S_F_PLNK: begin
				mem_re   = 1'b1;
				acc_addr = pb_q;
			end
			S_F_PWR: begin
				mem_we = 1'b1;
				if (step_q == 4'd0) begin
					acc_addr = pb_q;
					wdata    = ns_q;
				end else begin
					acc_addr = pb_q + OVM1 + AW'(ns_q);
					wdata    = ns_q;
					w_last   = 1'b1;
				end
			end
			S_F_HRD: begin
				mem_re   = 1'b1;
				acc_addr = AW'(1);
			end
			S_F_HWR: begin
				mem_we = 1'b1;
				case (step_q)
					4'd0: begin acc_addr = b_q + AW'(1); wdata = h_q; end
					4'd1: begin acc_addr = AW'(h_q) + AW'(2); wdata = b_q[WW-1:0]; end
					4'd2: begin acc_addr = b_q + AW'(2); wdata = '0; end
					default: begin
						acc_addr = AW'(1);
						wdata    = b_q[WW-1:0];
						w_last   = 1'b1;
					end
				endcase
			end
			S_I_WR: begin
				mem_we = 1'b1;
				case (step_q)
					4'd0: begin acc_addr = '0; wdata = '0; end
					4'd1: begin acc_addr = AW'(1); wdata = OV[WW-1:0]; end
					4'd2: begin acc_addr = AW'(2); wdata = OV[WW-1:0]; end
					4'd3: begin acc_addr = OVM1; wdata = '0; end
					4'd4: begin acc_addr = OV + AW'(1); wdata = '0; end
					4'd5: begin acc_addr = OV + AW'(2); wdata = '0; end
					4'd6: begin acc_addr = OV; wdata = WW'(pw - OV2); end
					default: begin
						acc_addr = pw - AW'(1);
						wdata    = WW'(pw - OV2);
						w_last   = 1'b1;
					end
				endcase
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we && in_range) begin
			mem[acc_addr[MAW-1:0]] <= wdata;
		end
		if (mem_re) begin
			mem_q <= mem[acc_addr[MAW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_oob_q <= 1'b0;
		end else if (mem_re) begin
			rd_oob_q <= !in_range;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q <= item.command;
					req_q <= item.request_size;
					fa_q  <= item.free_address;
				end
			end
			S_DISP: begin
				b_q    <= (cmd_q == btnf_pkg::CMD_FREE) ? b_free : rover_q;
				n_q    <= '0;
				step_q <= '0;
			end
			S_A_S: s_q <= rdata;
			S_A_ADV: begin
				b_q <= rd_x;
				n_q <= n_q + AW'(1);
			end
			S_A_BN: bn_q <= rdata;
			S_A_BP: begin
				bp_q    <= rdata;
				whole_q <= AW'(s_q) < req_x + OV;
				nb_q    <= b_q + OV + req_x;
				ns_q    <= WW'(AW'(s_q) - OV - req_x);
				step_q  <= '0;
			end
			S_F_SIZE: begin
				s_q  <= rdata;
				nb_q <= nb_free;
			end
			S_F_NLNK: nn_q <= rdata;
			S_F_NP: np_q <= rdata;
			S_F_NS: begin
				s_q    <= WW'(AW'(s_q) + rd_x + OV);
				step_q <= '0;
			end
			S_F_PF: pb_q <= pb_calc;
			S_F_PS: begin
				ns_q   <= WW'(rd_x + AW'(s_q) + OV);
				step_q <= '0;
			end
			S_F_H: begin
				h_q    <= rdata;
				step_q <= '0;
			end
			S_A_WR, S_F_MWR, S_F_PWR, S_F_HWR, S_I_WR: step_q <= step_q + 4'd1;
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rover_q   <= '0;
			active_q  <= 1'b0;
			limit_q   <= '0;
			ok_q      <= 1'b0;
			addr_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					ok_q   <= 1'b0;
					addr_q <= '0;
					case (cmd_q)
						btnf_pkg::CMD_ALLOC: begin
							state_q <= active_q ? S_A_CHK : S_FIN;
						end
						btnf_pkg::CMD_FREE: begin
							if (!active_q || fa_x >= AW'(limit_q) || fa_x < OV2M1) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_F_LINK;
							end
						end
						btnf_pkg::CMD_INIT: begin
							if (pw < OV2 || pw > DEPTH || pw > btnf_pkg::ADDR_SPACE) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_I_WR;
							end
						end
						default: begin
							active_q <= 1'b0;
							rover_q  <= '0;
							limit_q  <= '0;
							ok_q     <= 1'b1;
							state_q  <= S_FIN;
						end
					endcase
				end
				S_A_CHK: begin
					if (b_q >= AW'(limit_q)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= (b_q != '0) ? S_A_S : S_A_ADV;
					end
				end
				S_A_S: state_q <= (rdata >= WW'(req_q)) ? S_A_BN : S_A_ADV;
				S_A_ADV: begin
					if (rd_x == rover_q || n_q == DEPTH) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_A_CHK;
					end
				end
				S_A_BN: state_q <= S_A_BP;
				S_A_BP: state_q <= S_A_WR;
				S_A_WR: begin
					if (w_last) begin
						rover_q <= whole_q ? AW'(bn_q) : nb_q;
						ok_q    <= 1'b1;
						addr_q  <= 12'(b_q + OVM1);
						state_q <= S_FIN;
					end
				end
				S_F_LINK: state_q <= (rdata != btnf_pkg::NULL_LINK) ? S_FIN : S_F_SIZE;
				S_F_SIZE: state_q <= (nb_free < AW'(limit_q)) ? S_F_NLNK : S_F_PFR;
				S_F_NLNK: state_q <= (rdata != btnf_pkg::NULL_LINK) ? S_F_NP : S_F_PFR;
				S_F_NP: state_q <= S_F_NS;
				S_F_NS: begin
					if (nb_q == rover_q) begin
						rover_q <= AW'(nn_q);
					end
					state_q <= S_F_MWR;
				end
				S_F_MWR: begin
					if (w_last) begin
						state_q <= S_F_PFR;
					end
				end
				S_F_PFR: state_q <= S_F_PF;
				S_F_PF: begin
					if (rd_x + OV <= b_q && pb_calc != '0) begin
						state_q <= S_F_PLNK;
					end else begin
						state_q <= S_F_HRD;
					end
				end
				S_F_PLNK: state_q <= (rdata != btnf_pkg::NULL_LINK) ? S_F_PS : S_F_HRD;
				S_F_PS: begin
					if (b_q == rover_q) begin
						rover_q <= pb_q;
					end
					state_q <= S_F_PWR;
				end
				S_F_PWR: begin
					if (w_last) begin
						ok_q    <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_F_HRD: state_q <= S_F_H;
				S_F_H: state_q <= S_F_HWR;
				S_F_HWR: begin
					if (w_last) begin
						ok_q    <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_I_WR: begin
					if (w_last) begin
						rover_q  <= OV;
						limit_q  <= pool_words;
						active_q <= 1'b1;
						ok_q     <= 1'b1;
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_room) begin
						res_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.payload_address = ok_q ? addr_q : '0;
	assign res.ok              = ok_q;
endmodule
`default_nettype wire

/* design/boundary_tag_next_fit_allocator.sv */
// Top level of the boundary-tag next-fit pool allocator: handshakes,
// config register and result register. Depends on btnf_pkg and btnf_core.
//
//   channel | direction | handshake           | payload
//   cfg     | in        | cfg_valid/cfg_ready | pool_words
//   in      | in        | in_valid/in_ready   | command, request_size, free_address
//   out     | out       | out_valid/out_ready | payload_address, ok
//
// One command at a time, free-list state in a single-port pool memory (one access
// per cycle, registered read).
// Reset clears the control state; pool memory holds garbage until init.
// A pending result waits in the output register while the next beat is taken.
`default_nettype none
module boundary_tag_next_fit_allocator #(
	parameter int POOL_DEPTH     = 4096,
	parameter int BLOCK_OVERHEAD = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [12:0] pool_words,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [11:0] request_size,
	input  wire logic [11:0] free_address,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [11:0]      payload_address,
	output logic             ok
);
	logic [12:0]     pool_words_q;
	logic            core_idle, res_valid, res_room;
	btnf_pkg::item_t item;
	btnf_pkg::res_t  res;
	logic [11:0]     payload_address_q;
	logic            ok_q, out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = core_idle;
	assign res_room  = !out_valid_q || out_ready;

	assign item.command      = command;
	assign item.request_size = request_size;
	assign item.free_address = free_address;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_words_q <= 13'd4096;
		end else if (cfg_valid) begin
			pool_words_q <= pool_words;
		end
	end

	btnf_core #(
		.POOL_DEPTH    (POOL_DEPTH),
		.BLOCK_OVERHEAD(BLOCK_OVERHEAD)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && core_idle),
		.item      (item),
		.pool_words(pool_words_q),
		.res_room  (res_room),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			payload_address_q <= res.payload_address;
			ok_q              <= res.ok;
		end
	end

	assign out_valid       = out_valid_q;
	assign payload_address = payload_address_q;
	assign ok              = ok_q;
endmodule
`default_nettype wire
